### rtl/core/imufpp_pkg.sv
// ----------------------------------------------------------------------------
// imufpp_pkg
// Shared constants and types for the IMU frame pair parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imufpp_pkg;

  localparam logic [7:0] SyncByte  = 8'h55;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAccel = 8'h51;

  localparam int unsigned SumLen   = 10;
  localparam int unsigned FrameLen = 11;
  localparam int unsigned PosW     = 4;
  localparam int unsigned NumWords = 3;
  localparam int unsigned NumBytes = 2 * NumWords;

  localparam logic [PosW-1:0] PosHunt      = PosW'(0);
  localparam logic [PosW-1:0] PosType      = PosW'(1);
  localparam logic [PosW-1:0] PosData0     = PosW'(2);
  localparam logic [PosW-1:0] PosLastData  = PosW'(PosData0 + NumBytes - 1);
  localparam logic [PosW-1:0] PosChecksum  = PosW'(SumLen);
  localparam logic [PosW-1:0] PosFrameLen  = PosW'(FrameLen);

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } imufpp_result_t;

endpackage

`default_nettype wire

### rtl/core/imu_frame_pair_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_pair_parser
// Streaming parser that pairs a rate frame with the next acceleration frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) carries one received
//   serial byte per beat. Output channel (out_valid_o / out_ready_i) carries
//   one result of six signed 16-bit words: the held rate words and the words
//   of the acceleration frame that completes the pair.
//   A beat lands in an input register and is parsed from there, and any result
//   it makes is loaded into the output register, which drives out_valid_o.
//   Throughput is one byte per cycle; the input register and the output
//   register keep both sides moving, so in_ready_o only drops while a result
//   waits untaken in the output register and the byte behind it would make another.
//   When the receiver stalls, the result holds steady until taken.
//   Reset clears the frame position, checksum and pair phase: the block hunts
//   for sync and awaits a rate frame. Bytes other than sync are dropped while
//   hunting.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_pair_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      rate_x_o,
  output logic signed [15:0]      rate_y_o,
  output logic signed [15:0]      rate_z_o,
  output logic signed [15:0]      accel_x_o,
  output logic signed [15:0]      accel_y_o,
  output logic signed [15:0]      accel_z_o
);
  import imufpp_pkg::*;

  logic           in_valid_q;
  logic [7:0]     byte_q;
  logic           advance;
  logic           res_valid;
  imufpp_result_t res;
  logic           out_valid_q;
  imufpp_result_t out_q;

  // hold the byte only when it makes a result and the output slot is full and not being taken
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  imufpp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_x_o    = out_q.rate_x;
  assign rate_y_o    = out_q.rate_y;
  assign rate_z_o    = out_q.rate_z;
  assign accel_x_o   = out_q.accel_x;
  assign accel_y_o   = out_q.accel_y;
  assign accel_z_o   = out_q.accel_z;

endmodule

`default_nettype wire

### rtl/core/imufpp_parser.sv
// ----------------------------------------------------------------------------
// imufpp_parser
// Per-beat frame tracker: sync hunt, checksum, rate hold and pair output.
// ----------------------------------------------------------------------------
`default_nettype none

module imufpp_parser (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [7:0]                  byte_i,
  output logic                             res_valid_o,
  output imufpp_pkg::imufpp_result_t       res_o
);
  import imufpp_pkg::*;

  localparam int unsigned IdxW = $clog2(NumBytes);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic            phase_q, phase_d;
  logic [7:0]      pay_q   [NumBytes];
  logic [15:0]     rates_q [NumWords];

  logic [7:0]      want_type;
  logic [IdxW-1:0] pay_idx;
  logic            pay_we;
  logic            frame_ok;
  logic            hunting;

  assign want_type = phase_q ? TypeAccel : TypeRate;
  assign hunting   = (pos_q == PosHunt) || (pos_q >= PosFrameLen);
  assign pay_idx   = IdxW'(pos_q - PosData0);
  assign pay_we    = !hunting && (pos_q >= PosData0) && (pos_q <= PosLastData);
  assign frame_ok  = (pos_q == PosChecksum) && (byte_i == sum_q);

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    phase_d = phase_q;
    if (hunting || (pos_q == PosType && byte_i != want_type) ||
        (pos_q == PosChecksum && byte_i != sum_q)) begin
      // drop the frame; a sync byte starts a new one right away
      if (byte_i == SyncByte) begin
        pos_d = PosType;
        sum_d = byte_i;
      end else begin
        pos_d = PosHunt;
        sum_d = 8'h00;
      end
    end else if (pos_q == PosChecksum) begin
      pos_d   = PosHunt;
      sum_d   = 8'h00;
      phase_d = !phase_q;
    end else begin
      pos_d = pos_q + PosW'(1);
      sum_d = sum_q + byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      sum_q   <= 8'h00;
      phase_q <= 1'b0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && pay_we) begin
      pay_q[pay_idx] <= byte_i;
    end
    if (step_i && frame_ok && !phase_q) begin
      for (int k = 0; k < NumWords; k++) begin
        rates_q[k] <= {pay_q[2*k+1], pay_q[2*k]};
      end
    end
  end

  assign res_valid_o   = frame_ok && phase_q;
  assign res_o.rate_x  = rates_q[0];
  assign res_o.rate_y  = rates_q[1];
  assign res_o.rate_z  = rates_q[2];
  assign res_o.accel_x = {pay_q[1], pay_q[0]};
  assign res_o.accel_y = {pay_q[3], pay_q[2]};
  assign res_o.accel_z = {pay_q[5], pay_q[4]};

endmodule

`default_nettype wire

### rtl/core/imufpp_checker.sv
// ----------------------------------------------------------------------------
// imufpp_checker
// Port-level checks for the IMU frame pair parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module imufpp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] rate_x_o,
  input wire logic signed [15:0] accel_z_o
);

  // result beat holds while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rate_x_o) && $stable(accel_z_o))
    else $error("result payload changed while stalled");

  // with the output slot empty nothing can hold the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output slot");

  // a new result comes from a byte parsed in a cycle that took input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared without a parse step");

endmodule

bind imu_frame_pair_parser imufpp_checker u_imufpp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .rate_x_o   (rate_x_o),
  .accel_z_o  (accel_z_o)
);

`default_nettype wire
